[rtl/core/lmc_pkg.sv]
// Shared types, constants and mode tables of the light mode controller.
// No dependencies; every other file of the block imports this package.
package lmc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [CFG_INDEX_W-1:0] lmc_cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]  lmc_cfg_data_t;

	localparam lmc_cfg_idx_t REG_BATTERY_LOW      = 3'd0;
	localparam lmc_cfg_idx_t REG_BATTERY_CRITICAL = 3'd1;
	localparam lmc_cfg_idx_t REG_TEMP_HIGH        = 3'd2;
	localparam lmc_cfg_idx_t REG_TEMP_LOW         = 3'd3;
	localparam lmc_cfg_idx_t REG_TURBO_LIMIT      = 3'd4;
	localparam lmc_cfg_idx_t REG_LONG_PRESS       = 3'd5;
	localparam lmc_cfg_idx_t REG_MOMENTARY        = 3'd6;
	localparam lmc_cfg_idx_t REG_CHECK_DELAY      = 3'd7;

	localparam logic [7:0]  RST_BATTERY_LOW      = 8'd130;
	localparam logic [7:0]  RST_BATTERY_CRITICAL = 8'd120;
	localparam logic [7:0]  RST_TEMP_HIGH        = 8'd120;
	localparam logic [7:0]  RST_TEMP_LOW         = 8'd100;
	localparam logic [15:0] RST_TURBO_LIMIT      = 16'd5625;
	localparam logic [7:0]  RST_LONG_PRESS       = 8'd32;
	localparam logic [7:0]  RST_MOMENTARY        = 8'd128;
	localparam logic [11:0] RST_CHECK_DELAY      = 12'd188;

	localparam logic [11:0] TEMP_WAIT_AFTER_DOWN = 12'd2000;
	localparam logic [2:0]  CONFIRM_COUNT        = 3'd4;
	localparam logic [2:0]  COUNT_LIMIT          = 3'd7;
	localparam logic [7:0]  FULL_LEVEL           = 8'd255;

	localparam logic [1:0] PWM_OFF   = 2'd0;
	localparam logic [1:0] PWM_PHASE = 2'd1;
	localparam logic [1:0] PWM_FAST  = 2'd2;

	typedef struct packed {
		logic       switch_down;
		logic       conversion_done;
		logic [7:0] sample_value;
	} lmc_item_t;

	typedef struct packed {
		logic [2:0] mode_number;
		logic [7:0] main_level;
		logic [7:0] second_level;
		logic [1:0] pwm_kind;
		logic       momentary_active;
		logic       measure_temperature;
		logic       start_conversion;
	} lmc_result_t;

	typedef struct packed {
		logic [7:0]  battery_low_level;
		logic [7:0]  battery_critical_level;
		logic [7:0]  temperature_high_level;
		logic [7:0]  temperature_low_level;
		logic [15:0] turbo_limit_ticks;
		logic [7:0]  long_press_ticks;
		logic [7:0]  momentary_ticks;
		logic [11:0] check_delay_ticks;
	} lmc_cfg_t;

	function automatic logic [7:0] main_level_of(input logic [2:0] mode);
		logic [7:0] lvl;
		unique case (mode)
			3'd0: lvl = 8'd0;
			3'd1: lvl = 8'd0;
			3'd2: lvl = 8'd32;
			3'd3: lvl = 8'd125;
			default: lvl = FULL_LEVEL;
		endcase
		return lvl;
	endfunction

	function automatic logic [7:0] second_level_of(input logic [2:0] mode);
		logic [7:0] lvl;
		unique case (mode)
			3'd0: lvl = 8'd0;
			3'd1: lvl = 8'd2;
			3'd2: lvl = 8'd32;
			3'd3: lvl = 8'd125;
			default: lvl = FULL_LEVEL;
		endcase
		return lvl;
	endfunction

	function automatic logic [1:0] pwm_kind_of(input logic [2:0] mode);
		logic [1:0] kind;
		unique case (mode)
			3'd0: kind = PWM_OFF;
			3'd1: kind = PWM_PHASE;
			default: kind = PWM_FAST;
		endcase
		return kind;
	endfunction

	function automatic logic [2:0] sat3(input logic [2:0] v);
		return (v < COUNT_LIMIT) ? v + 3'd1 : COUNT_LIMIT;
	endfunction

endpackage

[rtl/core/lmc_cfg_regs.sv]
// Configuration register file of the light mode controller.
// Depends on lmc_pkg for the register codes, reset values and the settings struct.
module lmc_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  lmc_pkg::lmc_cfg_idx_t  wr_index,
	input  lmc_pkg::lmc_cfg_data_t wr_data,
	output lmc_pkg::lmc_cfg_t    cfg
);
	import lmc_pkg::*;

	lmc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_low_level      <= RST_BATTERY_LOW;
			cfg_q.battery_critical_level <= RST_BATTERY_CRITICAL;
			cfg_q.temperature_high_level <= RST_TEMP_HIGH;
			cfg_q.temperature_low_level  <= RST_TEMP_LOW;
			cfg_q.turbo_limit_ticks      <= RST_TURBO_LIMIT;
			cfg_q.long_press_ticks       <= RST_LONG_PRESS;
			cfg_q.momentary_ticks        <= RST_MOMENTARY;
			cfg_q.check_delay_ticks      <= RST_CHECK_DELAY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BATTERY_LOW:      cfg_q.battery_low_level      <= wr_data[7:0];
				REG_BATTERY_CRITICAL: cfg_q.battery_critical_level <= wr_data[7:0];
				REG_TEMP_HIGH:        cfg_q.temperature_high_level <= wr_data[7:0];
				REG_TEMP_LOW:         cfg_q.temperature_low_level  <= wr_data[7:0];
				REG_TURBO_LIMIT:      cfg_q.turbo_limit_ticks      <= wr_data;
				REG_LONG_PRESS:       cfg_q.long_press_ticks       <= wr_data[7:0];
				REG_MOMENTARY:        cfg_q.momentary_ticks        <= wr_data[7:0];
				REG_CHECK_DELAY:      cfg_q.check_delay_ticks      <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/lmc_core.sv]
// Tick state of the light mode controller and its single-pass next-state logic.
// Depends on lmc_pkg for the item, result and settings types and the mode tables.
module lmc_core #(
	parameter int MODE_COUNT = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  lmc_pkg::lmc_item_t   item,
	input  lmc_pkg::lmc_cfg_t    cfg,
	output lmc_pkg::lmc_result_t result
);
	import lmc_pkg::*;

	localparam logic [2:0] MODE_MAX  = 3'(MODE_COUNT - 1);
	localparam logic [2:0] MOM_INDEX = (MODE_COUNT - 1 < 4) ? 3'(MODE_COUNT - 1) : 3'd4;

	function automatic logic [2:0] step_up(input logic [2:0] m);
		return (m >= MODE_MAX) ? 3'd0 : m + 3'd1;
	endfunction

	function automatic logic [2:0] step_down(input logic [2:0] m);
		return (m == 3'd0 || m > MODE_MAX) ? MODE_MAX : m - 3'd1;
	endfunction

	logic [3:0]  hist_q,  hist_n;
	logic [7:0]  press_q, press_n;
	logic [2:0]  mode_q,  mode_n;
	logic [2:0]  top_q,   top_n;
	logic        mom_q,   mom_n;
	logic [15:0] turbo_q, turbo_n;
	logic [11:0] bw_q,    bw_n;
	logic [11:0] tw_q,    tw_n;
	logic [2:0]  lbc_q,   lbc_n;
	logic [2:0]  hot_q,   hot_n;
	logic [2:0]  cool_q,  cool_n;
	logic        tsel_q,  tsel_n;
	logic        start;
	logic [7:0]  bat_thr, hot_thr, cool_thr;

	always_comb begin
		hist_n   = {hist_q[2:0], item.switch_down};
		press_n  = press_q;
		mode_n   = mode_q;
		top_n    = top_q;
		mom_n    = mom_q;
		turbo_n  = turbo_q;
		bw_n     = bw_q;
		tw_n     = tw_q;
		lbc_n    = lbc_q;
		hot_n    = hot_q;
		cool_n   = cool_q;
		tsel_n   = tsel_q;
		start    = 1'b0;
		bat_thr  = cfg.battery_low_level;
		hot_thr  = cfg.temperature_high_level;
		cool_thr = cfg.temperature_low_level;

		if (hist_n != 4'd0) begin
			if (press_n != 8'hFF) begin
				press_n = press_n + 8'd1;
			end
			if (mom_q) begin
				mode_n = MOM_INDEX;
				if (press_n == cfg.momentary_ticks) begin
					mode_n = 3'd0;
					mom_n  = 1'b0;
				end
			end else begin
				if (press_n == cfg.long_press_ticks) begin
					mode_n = step_down(mode_n);
					top_n  = mode_n;
				end
				if (press_n == cfg.momentary_ticks) begin
					mom_n   = 1'b1;
					press_n = 8'd0;
				end
				turbo_n = 16'd0;
				bw_n    = cfg.check_delay_ticks;
				tw_n    = cfg.check_delay_ticks;
			end
		end else if (mom_q) begin
			mode_n = 3'd0;
		end else begin
			if (press_q != 8'd0 && press_q < cfg.long_press_ticks) begin
				mode_n = step_up(mode_n);
				top_n  = mode_n;
			end else begin
				if (main_level_of(mode_n) == FULL_LEVEL) begin
					if (turbo_n != 16'hFFFF) begin
						turbo_n = turbo_n + 16'd1;
					end
					if (turbo_n > cfg.turbo_limit_ticks) begin
						mode_n = step_down(mode_n);
					end
				end
				if (bw_n != 12'd0) begin
					bw_n = bw_n - 12'd1;
				end
				if (tw_n != 12'd0) begin
					tw_n = tw_n - 12'd1;
				end
				if (item.conversion_done) begin
					if (!tsel_q) begin
						if (bw_n == 12'd0) begin
							bat_thr = (mode_n == 3'd1) ? cfg.battery_critical_level
							                           : cfg.battery_low_level;
							lbc_n = (item.sample_value < bat_thr) ? sat3(lbc_q) : 3'd0;
							if (lbc_n >= CONFIRM_COUNT) begin
								mode_n = step_down(mode_n);
								top_n  = mode_n;
								lbc_n  = 3'd0;
								bw_n   = cfg.check_delay_ticks;
								tw_n   = cfg.check_delay_ticks;
							end
						end
						tsel_n = 1'b1;
					end else begin
						if (tw_n == 12'd0) begin
							hot_thr = (mode_n == 3'd1) ? FULL_LEVEL
							                           : cfg.temperature_high_level;
							cool_thr = (main_level_of(mode_n) >= main_level_of(top_q))
							           ? 8'd0 : cfg.temperature_low_level;
							if (item.sample_value > hot_thr) begin
								hot_n = sat3(hot_q);
							end else if (item.sample_value < cool_thr) begin
								cool_n = sat3(cool_q);
							end else begin
								hot_n  = 3'd0;
								cool_n = 3'd0;
							end
							if (hot_n >= CONFIRM_COUNT) begin
								mode_n = step_down(mode_n);
								hot_n  = 3'd0;
								cool_n = 3'd0;
								tw_n   = TEMP_WAIT_AFTER_DOWN;
							end else if (cool_n >= CONFIRM_COUNT) begin
								mode_n = step_up(mode_n);
								hot_n  = 3'd0;
								cool_n = 3'd0;
								tw_n   = cfg.check_delay_ticks;
							end
						end
						tsel_n = 1'b0;
					end
				end
				start = 1'b1;
			end
			press_n = 8'd0;
		end

		if (mode_q != 3'd0 && mode_n == 3'd0) begin
			press_n = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= 4'd0;
			press_q <= 8'd0;
			mode_q  <= 3'd0;
			top_q   <= MODE_MAX;
			mom_q   <= 1'b0;
			turbo_q <= 16'd0;
			bw_q    <= RST_CHECK_DELAY;
			tw_q    <= RST_CHECK_DELAY;
			lbc_q   <= 3'd0;
			hot_q   <= 3'd0;
			cool_q  <= 3'd0;
			tsel_q  <= 1'b0;
		end else if (advance) begin
			hist_q  <= hist_n;
			press_q <= press_n;
			mode_q  <= mode_n;
			top_q   <= top_n;
			mom_q   <= mom_n;
			turbo_q <= turbo_n;
			bw_q    <= bw_n;
			tw_q    <= tw_n;
			lbc_q   <= lbc_n;
			hot_q   <= hot_n;
			cool_q  <= cool_n;
			tsel_q  <= tsel_n;
		end
	end

	assign result.mode_number         = mode_n;
	assign result.main_level          = main_level_of(mode_n);
	assign result.second_level        = second_level_of(mode_n);
	assign result.pwm_kind            = pwm_kind_of(mode_n);
	assign result.momentary_active    = mom_n;
	assign result.measure_temperature = tsel_n;
	assign result.start_conversion    = start;

`ifndef SYNTH
	a_modes_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q <= MODE_MAX) && (top_q <= MODE_MAX))
		else $error("Current or top mode beyond the mode table.");

	a_battery_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		lbc_q < CONFIRM_COUNT)
		else $error("Low battery count not cleared after confirmation.");

	a_temp_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(hot_q < CONFIRM_COUNT) && (cool_q < CONFIRM_COUNT))
		else $error("Temperature count not cleared after confirmation.");
`endif

endmodule

[rtl/core/light_mode_controller_top.sv]
// Top level of the light mode controller: input stage, result register and handshakes.
// Depends on lmc_pkg, lmc_cfg_regs and lmc_core.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    switch_down, conversion_done, sample_value
//   out       out_valid / out_ready  mode_number, main_level, second_level, pwm_kind,
//                                    momentary_active, measure_temperature,
//                                    start_conversion
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per clock cycle is sustained while out_ready stays high; a result is
// valid once its input transaction has passed from the input register through the core
// into the result register. Reset is asynchronous and restores all settings and tick
// state at once. When the result register is held by out_ready low, the input stage
// fills and then in_ready falls; configuration writes are always taken.
module light_mode_controller_top #(
	parameter int MODE_COUNT = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   switch_down,
	input  logic                   conversion_done,
	input  logic [7:0]             sample_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             mode_number,
	output logic [7:0]             main_level,
	output logic [7:0]             second_level,
	output logic [1:0]             pwm_kind,
	output logic                   momentary_active,
	output logic                   measure_temperature,
	output logic                   start_conversion,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  lmc_pkg::lmc_cfg_idx_t  cfg_index,
	input  lmc_pkg::lmc_cfg_data_t cfg_data
);
	import lmc_pkg::*;

	localparam logic [2:0] MODE_MAX = 3'(MODE_COUNT - 1);

	logic        valid_s1;
	lmc_item_t   item_s1;
	logic        out_valid_q;
	lmc_result_t result_q;
	lmc_result_t result;
	lmc_cfg_t    cfg;
	logic        advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.switch_down     <= switch_down;
			item_s1.conversion_done <= conversion_done;
			item_s1.sample_value    <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	lmc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lmc_core #(
		.MODE_COUNT (MODE_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign out_valid           = out_valid_q;
	assign mode_number         = result_q.mode_number;
	assign main_level          = result_q.main_level;
	assign second_level        = result_q.second_level;
	assign pwm_kind            = result_q.pwm_kind;
	assign momentary_active    = result_q.momentary_active;
	assign measure_temperature = result_q.measure_temperature;
	assign start_conversion    = result_q.start_conversion;

`ifndef SYNTH
	a_stall_only_on_full_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("Input stalled while the pipeline has room.");

	a_no_start_in_momentary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.start_conversion) |-> !result_q.momentary_active)
		else $error("Conversion started while momentary mode is armed.");

	a_result_mode_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.mode_number <= MODE_MAX))
		else $error("Result mode beyond the mode table.");
`endif

endmodule

[dv/lmc_light_checker.sv]
`timescale 1ns / 100ps
// Checker for the light mode controller: watches the input, result and settings channels,
// predicts every result tick by tick and compares it field by field. Depends on lmc_pkg.
module lmc_light_checker #(
	parameter int MODE_COUNT = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   switch_down,
	input  logic                   conversion_done,
	input  logic [7:0]             sample_value,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [2:0]             mode_number,
	input  logic [7:0]             main_level,
	input  logic [7:0]             second_level,
	input  logic [1:0]             pwm_kind,
	input  logic                   momentary_active,
	input  logic                   measure_temperature,
	input  logic                   start_conversion,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  lmc_pkg::lmc_cfg_idx_t  cfg_index,
	input  lmc_pkg::lmc_cfg_data_t cfg_data,
	output int                     fail_count,
	output int                     n_pending,
	output int                     checked_count,
	output int                     armed_count,
	output int                     start_count,
	output logic [7:0]             mode_seen
);
	import lmc_pkg::*;

	localparam int MAX_MODE = MODE_COUNT - 1;
	localparam int MOM_MODE = (MAX_MODE < 4) ? MAX_MODE : 4;

	localparam logic [63:0] MAIN_TAB = {8'd255, 8'd255, 8'd255, 8'd255,
		8'd125, 8'd32, 8'd0, 8'd0};
	localparam logic [63:0] SECOND_TAB = {8'd255, 8'd255, 8'd255, 8'd255,
		8'd125, 8'd32, 8'd2, 8'd0};
	localparam logic [15:0] KIND_TAB = {PWM_FAST, PWM_FAST, PWM_FAST, PWM_FAST,
		PWM_FAST, PWM_FAST, PWM_PHASE, PWM_OFF};

	lmc_cfg_t    settings;
	logic [3:0]  sw_hist;
	logic [7:0]  held_ticks;
	logic [2:0]  mode;
	logic [2:0]  top;
	logic        armed;
	logic [15:0] full_ticks;
	logic [11:0] batt_hold;
	logic [11:0] temp_hold;
	logic [2:0]  low_hits;
	logic [2:0]  hot_hits;
	logic [2:0]  cool_hits;
	logic        on_temp;

	lmc_result_t awaited_lights[$];

	function automatic logic [7:0] main_of(input logic [2:0] m);
		return MAIN_TAB[int'(m) * 8 +: 8];
	endfunction

	function automatic logic [2:0] mode_up(input logic [2:0] m);
		return (m >= MAX_MODE) ? 3'd0 : m + 3'd1;
	endfunction

	function automatic logic [2:0] mode_down(input logic [2:0] m);
		return (m == 3'd0 || m > MAX_MODE) ? 3'(MAX_MODE) : m - 3'd1;
	endfunction

	function automatic logic [2:0] bump(input logic [2:0] c);
		return (c < COUNT_LIMIT) ? c + 3'd1 : COUNT_LIMIT;
	endfunction

	function automatic lmc_result_t advance_tick(input logic sw, input logic dn,
			input logic [7:0] smp);
		lmc_result_t r;
		logic [2:0]  prev;
		logic        go;
		logic [7:0]  thr;
		logic [7:0]  hot_thr;
		logic [7:0]  cool_thr;
		prev = mode;
		go = 1'b0;
		sw_hist = {sw_hist[2:0], sw};
		if (sw_hist != 4'd0) begin
			if (held_ticks != 8'hFF)
				held_ticks = held_ticks + 8'd1;
			if (armed) begin
				mode = 3'(MOM_MODE);
				if (held_ticks == settings.momentary_ticks) begin
					mode = 3'd0;
					armed = 1'b0;
				end
			end else begin
				if (held_ticks == settings.long_press_ticks) begin
					mode = mode_down(mode);
					top = mode;
				end
				if (held_ticks == settings.momentary_ticks) begin
					armed = 1'b1;
					held_ticks = 8'd0;
				end
				full_ticks = 16'd0;
				batt_hold = settings.check_delay_ticks;
				temp_hold = settings.check_delay_ticks;
			end
		end else if (armed) begin
			mode = 3'd0;
		end else begin
			if (held_ticks != 8'd0 && held_ticks < settings.long_press_ticks) begin
				mode = mode_up(mode);
				top = mode;
			end else begin
				if (main_of(mode) == FULL_LEVEL) begin
					if (full_ticks != 16'hFFFF)
						full_ticks = full_ticks + 16'd1;
					if (full_ticks > settings.turbo_limit_ticks)
						mode = mode_down(mode);
				end
				if (batt_hold != 12'd0)
					batt_hold = batt_hold - 12'd1;
				if (temp_hold != 12'd0)
					temp_hold = temp_hold - 12'd1;
				if (dn && !on_temp) begin
					if (batt_hold == 12'd0) begin
						thr = (mode == 3'd1) ? settings.battery_critical_level
							: settings.battery_low_level;
						low_hits = (smp < thr) ? bump(low_hits) : 3'd0;
						if (low_hits >= CONFIRM_COUNT) begin
							mode = mode_down(mode);
							top = mode;
							low_hits = 3'd0;
							batt_hold = settings.check_delay_ticks;
							temp_hold = settings.check_delay_ticks;
						end
					end
					on_temp = 1'b1;
				end else if (dn) begin
					if (temp_hold == 12'd0) begin
						hot_thr = (mode == 3'd1) ? FULL_LEVEL : settings.temperature_high_level;
						cool_thr = (main_of(mode) >= main_of(top)) ? 8'd0
							: settings.temperature_low_level;
						if (smp > hot_thr) begin
							hot_hits = bump(hot_hits);
						end else if (smp < cool_thr) begin
							cool_hits = bump(cool_hits);
						end else begin
							hot_hits = 3'd0;
							cool_hits = 3'd0;
						end
						if (hot_hits >= CONFIRM_COUNT) begin
							mode = mode_down(mode);
							hot_hits = 3'd0;
							cool_hits = 3'd0;
							temp_hold = TEMP_WAIT_AFTER_DOWN;
						end else if (cool_hits >= CONFIRM_COUNT) begin
							mode = mode_up(mode);
							hot_hits = 3'd0;
							cool_hits = 3'd0;
							temp_hold = settings.check_delay_ticks;
						end
					end
					on_temp = 1'b0;
				end
				go = 1'b1;
			end
			held_ticks = 8'd0;
		end
		if (prev != 3'd0 && mode == 3'd0)
			held_ticks = 8'd0;
		r.mode_number = mode;
		r.main_level = main_of(mode);
		r.second_level = SECOND_TAB[int'(mode) * 8 +: 8];
		r.pwm_kind = KIND_TAB[int'(mode) * 2 +: 2];
		r.momentary_active = armed;
		r.measure_temperature = on_temp;
		r.start_conversion = go;
		return r;
	endfunction

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lmc_result_t want;
		if (!arst_n) begin
			settings.battery_low_level = RST_BATTERY_LOW;
			settings.battery_critical_level = RST_BATTERY_CRITICAL;
			settings.temperature_high_level = RST_TEMP_HIGH;
			settings.temperature_low_level = RST_TEMP_LOW;
			settings.turbo_limit_ticks = RST_TURBO_LIMIT;
			settings.long_press_ticks = RST_LONG_PRESS;
			settings.momentary_ticks = RST_MOMENTARY;
			settings.check_delay_ticks = RST_CHECK_DELAY;
			sw_hist = 4'd0;
			held_ticks = 8'd0;
			mode = 3'd0;
			top = 3'(MAX_MODE);
			armed = 1'b0;
			full_ticks = 16'd0;
			batt_hold = RST_CHECK_DELAY;
			temp_hold = RST_CHECK_DELAY;
			low_hits = 3'd0;
			hot_hits = 3'd0;
			cool_hits = 3'd0;
			on_temp = 1'b0;
			awaited_lights.delete();
			fail_count = 0;
			checked_count = 0;
			armed_count = 0;
			start_count = 0;
			mode_seen = 8'd0;
			n_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BATTERY_LOW:      settings.battery_low_level = cfg_data[7:0];
					REG_BATTERY_CRITICAL: settings.battery_critical_level = cfg_data[7:0];
					REG_TEMP_HIGH:        settings.temperature_high_level = cfg_data[7:0];
					REG_TEMP_LOW:         settings.temperature_low_level = cfg_data[7:0];
					REG_TURBO_LIMIT:      settings.turbo_limit_ticks = cfg_data;
					REG_LONG_PRESS:       settings.long_press_ticks = cfg_data[7:0];
					REG_MOMENTARY:        settings.momentary_ticks = cfg_data[7:0];
					REG_CHECK_DELAY:      settings.check_delay_ticks = cfg_data[11:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_lights.size() == 0) begin
					fail_count++;
					$display("%0t: result with no input transaction awaiting it, expected none, actual mode %0d",
						$time, mode_number);
				end else begin
					want = awaited_lights.pop_front();
					compare_field("mode_number", want.mode_number, mode_number);
					compare_field("main_level", want.main_level, main_level);
					compare_field("second_level", want.second_level, second_level);
					compare_field("pwm_kind", want.pwm_kind, pwm_kind);
					compare_field("momentary_active", want.momentary_active, momentary_active);
					compare_field("measure_temperature", want.measure_temperature,
						measure_temperature);
					compare_field("start_conversion", want.start_conversion, start_conversion);
				end
				checked_count++;
				mode_seen[mode_number] = 1'b1;
				if (momentary_active)
					armed_count++;
				if (start_conversion)
					start_count++;
			end
			if (in_valid && in_ready)
				awaited_lights.push_back(advance_tick(switch_down, conversion_done, sample_value));
			n_pending <= awaited_lights.size();
		end
	end

endmodule

[dv/tb_light_mode_controller_top.sv]
`timescale 1ns / 100ps
// Testbench top of the light mode controller: clock, reset, tick stimulus, settings phases
// and the verdict. Depends on lmc_pkg, light_mode_controller_top and lmc_light_checker.
module tb_light_mode_controller_top;
	import lmc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic          switch_down = 1'b0;
	logic          conversion_done = 1'b0;
	logic [7:0]    sample_value = 8'd0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [2:0]    mode_number;
	logic [7:0]    main_level;
	logic [7:0]    second_level;
	logic [1:0]    pwm_kind;
	logic          momentary_active;
	logic          measure_temperature;
	logic          start_conversion;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	lmc_cfg_idx_t  cfg_index = '0;
	lmc_cfg_data_t cfg_data = '0;

	int         fail_count;
	int         n_pending;
	int         checked_count;
	int         armed_count;
	int         start_count;
	logic [7:0] mode_seen;

	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	int phases_run = 1;
	int cur_long = RST_LONG_PRESS;
	int cur_mom = RST_MOMENTARY;
	int rx_cycle = 0;
	int rx_style = 0;
	int hold_left = 0;

	light_mode_controller_top uut (.*);

	lmc_light_checker #(.MODE_COUNT(5)) watch (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver changes its stall style now and then and holds off for a long stretch
	// at fixed points, so that the block fills and refuses input transactions.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_style = $urandom_range(0, 3);
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_cycle % 1200 == 600) begin
			hold_left = 80;
			out_ready <= 1'b0;
		end else begin
			case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_cycle % 3 != 0);
			endcase
		end
	end

	task automatic send_tick(input logic sw, input logic dn, input logic [7:0] smp);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		switch_down <= sw;
		conversion_done <= dn;
		sample_value <= smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input lmc_cfg_t s);
		lmc_cfg_data_t d;
		for (int i = 0; i < 8; i++) begin
			case (lmc_cfg_idx_t'(i))
				REG_BATTERY_LOW:      d = {8'($urandom), s.battery_low_level};
				REG_BATTERY_CRITICAL: d = {8'($urandom), s.battery_critical_level};
				REG_TEMP_HIGH:        d = {8'($urandom), s.temperature_high_level};
				REG_TEMP_LOW:         d = {8'($urandom), s.temperature_low_level};
				REG_TURBO_LIMIT:      d = s.turbo_limit_ticks;
				REG_LONG_PRESS:       d = {8'($urandom), s.long_press_ticks};
				REG_MOMENTARY:        d = {8'($urandom), s.momentary_ticks};
				default:              d = {4'($urandom), s.check_delay_ticks};
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= lmc_cfg_idx_t'(i);
			cfg_data <= d;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_long = s.long_press_ticks;
		cur_mom = s.momentary_ticks;
		phases_run++;
	endtask

	// At most one press of a chosen kind followed by a released stretch whose readings are
	// uniform or lean low, high or middle so that the confirmation counters fill.
	task automatic run_episode();
		int pick;
		int len;
		int lo;
		int hi;
		int rel;
		int lean;
		logic [7:0] smp;
		pick = $urandom_range(0, 9);
		len = 0;
		if (pick <= 3) begin
			hi = (cur_long > 2) ? cur_long - 2 : 1;
			len = $urandom_range(1, hi);
		end else if (pick <= 5) begin
			lo = (cur_long > 4) ? cur_long - 4 : 1;
			hi = (cur_mom + 1 > lo) ? cur_mom + 1 : lo + 4;
			len = $urandom_range(lo, hi);
		end else if (pick == 6) begin
			len = cur_mom + $urandom_range(0, 3);
		end
		if (len > 80)
			len = 80;
		for (int k = 0; k < len; k++)
			send_tick(1'b1, 1'($urandom), 8'($urandom));
		if (pick == 7) begin
			for (int k = $urandom_range(2, 10); k > 0; k--)
				send_tick(1'($urandom), 1'($urandom), 8'($urandom));
		end
		lean = $urandom_range(0, 3);
		rel = $urandom_range(2, 40);
		for (int k = 0; k < rel; k++) begin
			case (lean)
				0: smp = 8'($urandom_range(0, 255));
				1: smp = 8'($urandom_range(0, 60));
				2: smp = 8'($urandom_range(190, 255));
				default: smp = 8'($urandom_range(40, 210));
			endcase
			send_tick(1'b0, ($urandom_range(0, 7) != 0), smp);
		end
	endtask

	initial begin
		lmc_cfg_t s;
		int phase_end;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Five short presses at the reset settings walk every mode and wrap back to off.
		for (int i = 0; i < 5; i++) begin
			send_tick(1'b1, i[0], 8'hFF);
			for (int k = 0; k < 4; k++)
				send_tick(1'b0, k[0], (k < 2) ? 8'h00 : 8'hFF);
		end
		phase_end = items_sent + 30;
		while (items_sent < phase_end)
			run_episode();
		wait_drained();

		s = '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd1, 8'd1, 12'd0};
		write_settings(s);
		phase_end = items_sent + 50;
		while (items_sent < phase_end)
			run_episode();
		wait_drained();

		s = '{8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255, 12'hFFF};
		write_settings(s);
		for (int k = 0; k < 258; k++)
			send_tick(1'b1, 1'($urandom), 8'($urandom));
		phase_end = items_sent + 30;
		while (items_sent < phase_end)
			run_episode();
		wait_drained();

		s.battery_low_level = 8'd40;
		s.battery_critical_level = 8'd30;
		s.temperature_high_level = 8'd230;
		s.temperature_low_level = 8'd200;
		s.turbo_limit_ticks = 16'($urandom_range(0, 30));
		s.long_press_ticks = 8'($urandom_range(3, 12));
		s.momentary_ticks = 8'($urandom_range(14, 30));
		s.check_delay_ticks = 12'($urandom_range(0, 6));
		write_settings(s);
		phase_end = items_sent + 60;
		while (items_sent < phase_end)
			run_episode();
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			s.battery_low_level = 8'($urandom);
			s.battery_critical_level = 8'($urandom);
			s.temperature_high_level = 8'($urandom);
			s.temperature_low_level = 8'($urandom);
			s.turbo_limit_ticks = 16'($urandom_range(0, 40));
			s.long_press_ticks = 8'($urandom_range(1, 20));
			s.momentary_ticks = 8'($urandom_range(1, 40));
			s.check_delay_ticks = 12'($urandom_range(0, 12));
			write_settings(s);
			phase_end = items_sent + 60;
			while (items_sent < phase_end)
				run_episode();
			wait_drained();
		end

		@(negedge clk);
		$display("Ran %0d settings phases with %0d ticks; %0d results checked.",
			phases_run, items_sent, checked_count);
		$display("Modes reached (one bit per mode): %b; momentary armed on %0d results, conversions started on %0d.",
			mode_seen, armed_count, start_count);
		if (fail_count == 0 && n_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
